// ===== hdl/integer_area_downscale_defines.svh =====
// ----------------------------------------------------------------------------
// integer_area_downscale_defines.svh
// assertion macros shared by the area downscaler
// ----------------------------------------------------------------------------
`ifndef INTEGER_AREA_DOWNSCALE_DEFINES_SVH
`define INTEGER_AREA_DOWNSCALE_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define IAD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked on clk, off during reset
`define IAD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hdl/iad_pkg.sv =====
// ----------------------------------------------------------------------------
// iad_pkg
// shared types, codes and helpers of the integer area downscaler
// ----------------------------------------------------------------------------
package iad_pkg;

	// configuration port
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 13;
	localparam int OUT_WIDTH_BITS  = 11;
	localparam int OUT_HEIGHT_BITS = 13;
	localparam int FACTOR_BITS     = 5;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FACTOR_X   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FACTOR_Y   = 2'd3;

	// fixed limits and field widths
	localparam int MAX_OUT_HEIGHT = 4096;
	localparam int OUT_ROW_BITS   = 12;
	localparam int AVG_BITS       = 16;
	localparam int QUEUE_DEPTH    = 4;

	// what the front tells the back about a finished horizontal run
	typedef struct packed {
		logic first_row;   // first input row of the block row: no partial sum yet
		logic emit;        // last input row: block complete, produce a mean
		logic frame_last;  // block is the last of the frame
	} run_flags_t;

	// back-end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SUM,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// zero acts as one, anything above the limit acts as the limit
	function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
		int unsigned r;
		if (v == 0) r = 1;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

endpackage

// ===== hdl/iad_fifo.sv =====
// ----------------------------------------------------------------------------
// iad_fifo
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module iad_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH    = iad_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS = $clog2(DEPTH);

	logic [WIDTH-1:0]    slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	// status
	assign full      = (count_q == (PTR_BITS+1)'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/iad_front.sv =====
// ----------------------------------------------------------------------------
// iad_front
// configuration registers, raster position counters and horizontal run sums
// ----------------------------------------------------------------------------
module iad_front #(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int MAX_FACTOR    = 16,
	parameter int PIXEL_BITS    = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [iad_pkg::CFG_IDX_BITS-1:0]            cfg_index,
	input  logic [iad_pkg::CFG_DATA_BITS-1:0]           cfg_data,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [PIXEL_BITS-1:0]                       pixel,
	input  logic                                        queue_full,
	output logic                                        run_push,
	output logic [PIXEL_BITS+$clog2(MAX_FACTOR+1)-1:0]  run_sum,
	output logic [((MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1)-1:0] run_col,
	output iad_pkg::run_flags_t                         run_flags,
	output logic [$clog2(MAX_FACTOR*MAX_FACTOR+1)-1:0]  area
);

	localparam int F_BITS    = $clog2(MAX_FACTOR+1);
	localparam int FCNT_BITS = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int W_BITS    = $clog2(MAX_OUT_WIDTH+1);
	localparam int COL_BITS  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int ROW_BITS  = PIXEL_BITS + $clog2(MAX_FACTOR+1);
	localparam int AREA_BITS = $clog2(MAX_FACTOR*MAX_FACTOR+1);
	localparam int H_BITS    = iad_pkg::OUT_HEIGHT_BITS;
	localparam int OR_BITS   = iad_pkg::OUT_ROW_BITS;

	// clamped geometry
	logic [W_BITS-1:0]    w_q;
	logic [H_BITS-1:0]    h_q;
	logic [F_BITS-1:0]    fx_q;
	logic [F_BITS-1:0]    fy_q;

	// position and run accumulator
	logic [ROW_BITS-1:0]  row_sum_q;
	logic [FCNT_BITS-1:0] sub_col_q;
	logic [COL_BITS-1:0]  out_col_q;
	logic [FCNT_BITS-1:0] sub_row_q;
	logic [OR_BITS-1:0]   out_row_q;

	logic                 accept;
	logic                 run_done;
	logic                 col_last;
	logic                 sub_row_last;
	logic                 row_last;

	// position decode
	assign run_done     = ((F_BITS'(sub_col_q) + F_BITS'(1)) == fx_q);
	assign col_last     = ((W_BITS'(out_col_q) + W_BITS'(1)) == w_q);
	assign sub_row_last = ((F_BITS'(sub_row_q) + F_BITS'(1)) == fy_q);
	assign row_last     = ((H_BITS'(out_row_q) + H_BITS'(1)) == h_q);

	// a pixel that ends a run needs a queue slot
	assign s_tready = !run_done || !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign run_push = accept && run_done;

	// run description for the back
	assign run_sum              = row_sum_q + ROW_BITS'(pixel);
	assign run_col              = out_col_q;
	assign run_flags.first_row  = (sub_row_q == '0);
	assign run_flags.emit       = sub_row_last;
	assign run_flags.frame_last = row_last && col_last;

	// block area for the mean
	assign area = AREA_BITS'(fx_q) * AREA_BITS'(fy_q);

	// configuration and counters; any write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= W_BITS'(1);
			h_q       <= H_BITS'(1);
			fx_q      <= F_BITS'(1);
			fy_q      <= F_BITS'(1);
			row_sum_q <= '0;
			sub_col_q <= '0;
			out_col_q <= '0;
			sub_row_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iad_pkg::CFG_OUT_WIDTH: begin
					w_q <= W_BITS'(iad_pkg::clamp_reg(
						32'(cfg_data[iad_pkg::OUT_WIDTH_BITS-1:0]), MAX_OUT_WIDTH));
				end
				iad_pkg::CFG_OUT_HEIGHT: begin
					h_q <= H_BITS'(iad_pkg::clamp_reg(
						32'(cfg_data[iad_pkg::OUT_HEIGHT_BITS-1:0]), iad_pkg::MAX_OUT_HEIGHT));
				end
				iad_pkg::CFG_FACTOR_X: begin
					fx_q <= F_BITS'(iad_pkg::clamp_reg(
						32'(cfg_data[iad_pkg::FACTOR_BITS-1:0]), MAX_FACTOR));
				end
				iad_pkg::CFG_FACTOR_Y: begin
					fy_q <= F_BITS'(iad_pkg::clamp_reg(
						32'(cfg_data[iad_pkg::FACTOR_BITS-1:0]), MAX_FACTOR));
				end
			endcase
			row_sum_q <= '0;
			sub_col_q <= '0;
			out_col_q <= '0;
			sub_row_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (!run_done) begin
				row_sum_q <= run_sum;
				sub_col_q <= sub_col_q + 1'b1;
			end else begin
				row_sum_q <= '0;
				sub_col_q <= '0;
				if (!col_last) begin
					out_col_q <= out_col_q + 1'b1;
				end else begin
					out_col_q <= '0;
					if (!sub_row_last) begin
						sub_row_q <= sub_row_q + 1'b1;
					end else begin
						sub_row_q <= '0;
						out_row_q <= row_last ? '0 : out_row_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/iad_back.sv =====
// ----------------------------------------------------------------------------
// iad_back
// line store of partial column sums, rounding divider and output register
// ----------------------------------------------------------------------------
module iad_back #(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int MAX_FACTOR    = 16,
	parameter int PIXEL_BITS    = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        queue_empty,
	output logic                                        queue_pop,
	input  logic [PIXEL_BITS+$clog2(MAX_FACTOR+1)-1:0]  head_sum,
	input  logic [((MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1)-1:0] head_col,
	input  iad_pkg::run_flags_t                         head_flags,
	input  logic [$clog2(MAX_FACTOR*MAX_FACTOR+1)-1:0]  area,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [iad_pkg::AVG_BITS-1:0]                average,
	output logic                                        frame_end
);

	localparam int ROW_BITS  = PIXEL_BITS + $clog2(MAX_FACTOR+1);
	localparam int COL_BITS  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int AREA_BITS = $clog2(MAX_FACTOR*MAX_FACTOR+1);
	localparam int SUM_BITS  = PIXEL_BITS + AREA_BITS;
	localparam int NUM_BITS  = SUM_BITS + 1;
	localparam int R_BITS    = AREA_BITS + 1;
	localparam int DCNT_BITS = $clog2(PIXEL_BITS);

	iad_pkg::back_state_t state_q;
	iad_pkg::back_state_t state_d;

	// current run
	logic [ROW_BITS-1:0]  ent_sum_q;
	logic [COL_BITS-1:0]  ent_col_q;
	iad_pkg::run_flags_t  ent_flags_q;

	// line store
	logic [SUM_BITS-1:0]  col_mem [MAX_OUT_WIDTH];
	logic [SUM_BITS-1:0]  rd_data_q;

	// divider
	logic [R_BITS-1:0]    rem_q;
	logic [PIXEL_BITS-1:0] quo_q;
	logic [DCNT_BITS-1:0] div_cnt_q;
	logic [R_BITS:0]      trial;
	logic [R_BITS:0]      divisor;
	logic [SUM_BITS-1:0]  total;
	logic [NUM_BITS-1:0]  numer;
	logic                 div_last;

	// output register
	logic                 out_valid_q;
	logic [iad_pkg::AVG_BITS-1:0] out_avg_q;
	logic                 out_last_q;
	logic                 slot_free;

	// sequencer strobes
	logic                 mem_we;
	logic                 div_load;
	logic                 div_step;
	logic                 out_load;

	// block sum and rounded-mean numerator 2*sum + area over 2*area
	assign total    = (ent_flags_q.first_row ? '0 : rd_data_q) + SUM_BITS'(ent_sum_q);
	assign numer    = {total, 1'b0} + NUM_BITS'(area);
	assign divisor  = {1'b0, area, 1'b0};
	assign trial    = {rem_q, quo_q[PIXEL_BITS-1]};
	assign div_last = (div_cnt_q == DCNT_BITS'(PIXEL_BITS-1));
	assign slot_free = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iad_pkg::BK_IDLE: if (!queue_empty) state_d = iad_pkg::BK_SUM;
			iad_pkg::BK_SUM:  state_d = ent_flags_q.emit ? iad_pkg::BK_DIV : iad_pkg::BK_IDLE;
			iad_pkg::BK_DIV:  if (div_last) state_d = iad_pkg::BK_DONE;
			iad_pkg::BK_DONE: if (slot_free) state_d = iad_pkg::BK_IDLE;
			default:          state_d = iad_pkg::BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		queue_pop = 1'b0;
		mem_we    = 1'b0;
		div_load  = 1'b0;
		div_step  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			iad_pkg::BK_IDLE: queue_pop = !queue_empty;
			iad_pkg::BK_SUM: begin
				mem_we   = !ent_flags_q.emit;
				div_load = ent_flags_q.emit;
			end
			iad_pkg::BK_DIV:  div_step = 1'b1;
			iad_pkg::BK_DONE: out_load = slot_free;
			default: ;
		endcase
	end

	// line store, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we)    col_mem[ent_col_q] <= total;
		if (queue_pop) rd_data_q <= col_mem[head_col];
	end

	// run capture and restoring divider, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (queue_pop) begin
			ent_sum_q   <= head_sum;
			ent_col_q   <= head_col;
			ent_flags_q <= head_flags;
		end
		if (div_load) begin
			rem_q <= numer[NUM_BITS-1:PIXEL_BITS];
			quo_q <= numer[PIXEL_BITS-1:0];
		end else if (div_step) begin
			if (trial >= divisor) begin
				rem_q <= R_BITS'(trial - divisor);
				quo_q <= {quo_q[PIXEL_BITS-2:0], 1'b1};
			end else begin
				rem_q <= R_BITS'(trial);
				quo_q <= {quo_q[PIXEL_BITS-2:0], 1'b0};
			end
		end
		if (out_load) begin
			out_avg_q  <= iad_pkg::AVG_BITS'(quo_q);
			out_last_q <= ent_flags_q.frame_last;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iad_pkg::BK_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_load) div_cnt_q <= '0;
			else if (div_step) div_cnt_q <= div_cnt_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign average   = out_avg_q;
	assign frame_end = out_last_q;

endmodule

// ===== hdl/integer_area_downscale.sv =====
// ----------------------------------------------------------------------------
// integer_area_downscale
// box-filter downscaler: mean of each factor_x by factor_y block of luma
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream in input raster order, one transaction per
// pixel; block means leave on the m_ stream in output raster order, with
// tuser high on the last mean of a frame. The user sets geometry through
// the write port (cfg_we, cfg_index, cfg_data) only while the block is
// idle, which the block does not enforce; every write restarts the frame.
// The front takes one pixel per cycle; a pixel that closes a horizontal run
// needs a slot in the four-entry run queue and waits while it is full. The
// back pops a run in BK_IDLE and forms its column sum in BK_SUM, writing it
// to the line store; a run that completes a block goes on to BK_DIV, where
// the restoring divider makes one quotient bit per cycle, and to BK_DONE,
// where the mean enters the output register once it is free and m_tvalid
// rises. Input rows that only update the line store run at one pixel per
// cycle for factor_x of 2 or more; for factor_x of 1 the back falls behind.
// In the last input row of a block row every run completes a block, so once
// the queue is full each run-ending pixel waits on the divider. Reset clears
// counters, queue and output valid, and sets every configuration register
// to 1; the line store is not cleared. If m_tready stays low the finished
// mean waits in the output register, the back then stalls, the queue fills
// and s_tready falls on the next run-ending pixel.
// ----------------------------------------------------------------------------
module integer_area_downscale #(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int MAX_FACTOR    = 16,
	parameter int PIXEL_BITS    = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [iad_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [iad_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]         s_tdata,   // pixel
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [iad_pkg::AVG_BITS-1:0]            m_tdata,   // average
	output logic                                    m_tuser    // frame_end
);

	`include "integer_area_downscale_defines.svh"

	localparam int ROW_BITS  = PIXEL_BITS + $clog2(MAX_FACTOR+1);
	localparam int COL_BITS  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int AREA_BITS = $clog2(MAX_FACTOR*MAX_FACTOR+1);
	localparam int FLAG_BITS = $bits(iad_pkg::run_flags_t);
	localparam int ENT_BITS  = ROW_BITS + COL_BITS + FLAG_BITS;

	logic                  run_push;
	logic [ROW_BITS-1:0]   run_sum;
	logic [COL_BITS-1:0]   run_col;
	iad_pkg::run_flags_t   run_flags;
	logic [AREA_BITS-1:0]  area;

	logic                  queue_full;
	logic                  queue_empty;
	logic                  queue_pop;
	logic [ENT_BITS-1:0]   head_data;
	logic [ROW_BITS-1:0]   head_sum;
	logic [COL_BITS-1:0]   head_col;
	iad_pkg::run_flags_t   head_flags;

	// front: configuration, positions and run sums
	iad_front #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.MAX_FACTOR   (MAX_FACTOR),
		.PIXEL_BITS   (PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.pixel     (s_tdata[PIXEL_BITS-1:0]),
		.queue_full(queue_full),
		.run_push  (run_push),
		.run_sum   (run_sum),
		.run_col   (run_col),
		.run_flags (run_flags),
		.area      (area)
	);

	// run queue
	iad_fifo #(
		.WIDTH(ENT_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (run_push),
		.push_data({run_flags, run_col, run_sum}),
		.pop      (queue_pop),
		.head_data(head_data),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	assign head_sum   = head_data[ROW_BITS-1:0];
	assign head_col   = head_data[ROW_BITS +: COL_BITS];
	assign head_flags = iad_pkg::run_flags_t'(head_data[ENT_BITS-1 -: FLAG_BITS]);

	// back: line store, divider, output register
	iad_back #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.MAX_FACTOR   (MAX_FACTOR),
		.PIXEL_BITS   (PIXEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_empty(queue_empty),
		.queue_pop  (queue_pop),
		.head_sum   (head_sum),
		.head_col   (head_col),
		.head_flags (head_flags),
		.area       (area),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.average    (m_tdata),
		.frame_end  (m_tuser)
	);

	// checks
	`IAD_ASSERT_IMPL(a_no_push_when_full, run_push, !queue_full)
	`IAD_ASSERT_IMPL(a_no_pop_when_empty, queue_pop, !queue_empty)
	`IAD_ASSERT_IMPL(a_stall_only_on_full, !s_tready, queue_full)
	`IAD_ASSERT_NEXT(a_pop_leaves_slot, queue_pop && !run_push, !queue_full)

endmodule
